// File: design/qrpv_pkg.sv
// shared types, constants and helpers for the query/report packet validator
package qrpv_pkg;

  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_MAX = 3'd7;
  localparam logic [POS_W-1:0] TAIL_START = 3'd5;   // first offset after the header
  localparam logic [POS_W-1:0] LAST_POS_MIN = 3'd4;  // last offset of a minimum-length payload
  localparam logic [POS_W-1:0] LAST_POS_MIN_AVAIL = 3'd5;

  localparam logic [7:0] OPCODE_MAX = 8'h09;
  localparam logic [3:0] OP_HEARTBEAT = 4'h3;
  localparam logic [3:0] OP_AVAIL = 4'h9;

  localparam logic [2:0] REASON_OK = 3'd0;
  localparam logic [2:0] REASON_BAD_OPCODE = 3'd1;
  localparam logic [2:0] REASON_TOO_SHORT = 3'd2;
  localparam logic [2:0] REASON_BAD_CHAR = 3'd3;
  localparam logic [2:0] REASON_NO_NUL = 3'd4;

  typedef struct packed {
    logic       accept;
    logic [2:0] reason;
  } verdict_t;

  // tab through carriage return, or printable ascii
  function automatic logic char_allowed(input logic [7:0] c);
    char_allowed = ((c >= 8'h09) && (c <= 8'h0D)) || ((c >= 8'h20) && (c <= 8'h7E));
  endfunction

endpackage

// File: design/qrpv_check.sv
// per-packet state and verdict logic, one byte per step
module qrpv_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output qrpv_pkg::verdict_t  verdict
);
  import qrpv_pkg::*;

  logic [POS_W-1:0] pos;
  logic [3:0]       opcode_seen;
  logic             opcode_bad;
  logic             char_bad;
  logic             null_found;

  logic [POS_W-1:0] pos_next;
  logic [3:0]       opcode_seen_next;
  logic             opcode_bad_next;
  logic             char_bad_next;
  logic             null_found_next;

  // flags after this byte has been checked
  logic [3:0] op_upd;
  logic       op_bad_upd;
  logic       char_bad_upd;
  logic       null_upd;
  logic       check_tail;

  always_comb begin
    op_upd = opcode_seen;
    op_bad_upd = opcode_bad;
    char_bad_upd = char_bad;
    null_upd = null_found;
    check_tail = 1'b0;
    if (pos == '0) begin
      op_bad_upd = data_byte > OPCODE_MAX;
      op_upd = data_byte[3:0];
    end else if ((pos >= TAIL_START) && !opcode_bad) begin
      // opcode 9 stops checking after its first nul
      check_tail = (opcode_seen == OP_HEARTBEAT) || ((opcode_seen == OP_AVAIL) && !null_found);
    end
    if (check_tail) begin
      if (data_byte == 8'h00) begin
        null_upd = 1'b1;
      end else if (!char_allowed(data_byte)) begin
        char_bad_upd = 1'b1;
      end
    end
  end

  always_comb begin
    verdict.reason = REASON_OK;
    priority if (op_bad_upd) begin
      verdict.reason = REASON_BAD_OPCODE;
    end else if (pos < LAST_POS_MIN) begin
      verdict.reason = REASON_TOO_SHORT;
    end else if ((op_upd == OP_AVAIL) && (pos < LAST_POS_MIN_AVAIL)) begin
      verdict.reason = REASON_TOO_SHORT;
    end else if ((op_upd == OP_HEARTBEAT) && (pos < TAIL_START)) begin
      verdict.reason = REASON_OK;
    end else if ((op_upd == OP_HEARTBEAT) || (op_upd == OP_AVAIL)) begin
      if (char_bad_upd) begin
        verdict.reason = REASON_BAD_CHAR;
      end else if (!null_upd) begin
        verdict.reason = REASON_NO_NUL;
      end
    end else begin
      verdict.reason = REASON_OK;
    end
    verdict.accept = (verdict.reason == REASON_OK);
  end

  always_comb begin
    pos_next = pos;
    opcode_seen_next = opcode_seen;
    opcode_bad_next = opcode_bad;
    char_bad_next = char_bad;
    null_found_next = null_found;
    if (step) begin
      if (last_byte) begin
        pos_next = '0;
        opcode_seen_next = '0;
        opcode_bad_next = 1'b0;
        char_bad_next = 1'b0;
        null_found_next = 1'b0;
      end else begin
        pos_next = (pos < POS_MAX) ? POS_W'(pos + 1'b1) : POS_MAX;
        opcode_seen_next = op_upd;
        opcode_bad_next = op_bad_upd;
        char_bad_next = char_bad_upd;
        null_found_next = null_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      opcode_seen <= '0;
      opcode_bad <= 1'b0;
      char_bad <= 1'b0;
      null_found <= 1'b0;
    end else begin
      pos <= pos_next;
      opcode_seen <= opcode_seen_next;
      opcode_bad <= opcode_bad_next;
      char_bad <= char_bad_next;
      null_found <= null_found_next;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last_byte |=> (pos == '0) && !opcode_bad && !char_bad && !null_found)
    else $error("packet state not cleared after last byte");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    step && !last_byte && (pos != POS_MAX) |=> pos == POS_W'($past(pos) + 1'b1))
    else $error("byte position did not advance");

  a_idle_state_clear: assert property (@(posedge clk) disable iff (rst)
    (pos == '0) |-> (opcode_seen == '0) && !opcode_bad && !char_bad && !null_found)
    else $error("stale packet state at offset zero");
`endif

endmodule

// File: design/query_report_packet_validator.sv
// top level: input register, packet checker and verdict output register
// slave to master side: input register, single check stage, verdict output register
// throughput: one byte per cycle unless a last byte waits on a busy verdict register
// a verdict appears only for a byte with tlast set; other bytes give no output
// a stalled master side holds a waiting verdict and still lets non-last bytes through
// synchronous reset clears both valid flags and all per-packet state
module query_report_packet_validator (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // last_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] accept, [3:1] reason, [7:4] zero
);
  import qrpv_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       res_valid;
  verdict_t   res;

  logic     res_free;
  logic     step;
  verdict_t verdict;

  assign res_free = !res_valid || m_axis_tready;
  // a non-last byte never needs the result register
  assign step = in_valid && (res_free || !in_last);
  assign s_axis_tready = !in_valid || step;

  qrpv_check u_check (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .data_byte (in_byte),
    .last_byte (in_last),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= step && in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && step && in_last) begin
      res <= verdict;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata = {4'b0000, res.reason, res.accept};

`ifndef SYNTHESIS
  a_accept_matches_reason: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.accept == (res.reason == REASON_OK))
    else $error("accept flag disagrees with reason");

  a_reason_known: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.reason == REASON_OK) || (res.reason == REASON_BAD_OPCODE) ||
                  (res.reason == REASON_TOO_SHORT) || (res.reason == REASON_BAD_CHAR) ||
                  (res.reason == REASON_NO_NUL))
    else $error("unknown reason code");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !step |=> in_valid && $stable(in_byte) && $stable(in_last))
    else $error("waiting byte lost from input register");

  a_last_needs_room: assert property (@(posedge clk) disable iff (rst)
    step && in_last |-> res_free)
    else $error("last byte stepped while verdict register busy");
`endif

endmodule

// File: dv/query_report_packet_validator_tb.sv
// self-checking testbench for the query/report packet validator stream block
module query_report_packet_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qrpv_pkg::*;

  // predicts one verdict per packet and checks verdicts in arrival order
  class packet_verdict_board;
    logic [2:0] pos;
    logic [3:0] op;
    logic       op_bad;
    logic       text_bad;
    logic       nul_seen;
    verdict_t   pending_verdicts[$];
    int         errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      pos = '0;
      op = '0;
      op_bad = 1'b0;
      text_bad = 1'b0;
      nul_seen = 1'b0;
    endfunction

    function bit is_text(logic [7:0] c);
      return c inside {[8'h09:8'h0D], [8'h20:8'h7E]};
    endfunction

    function int pending();
      return pending_verdicts.size();
    endfunction

    function void note_request(logic [7:0] b, logic l);
      verdict_t   v;
      logic [2:0] why;
      if (pos == '0) begin
        op_bad = b > OPCODE_MAX;
        op = b[3:0];
      end else if (pos >= TAIL_START && !op_bad) begin
        // opcode 9 stops looking after its first nul
        if (op == OP_HEARTBEAT || (op == OP_AVAIL && !nul_seen)) begin
          if (b == 8'h00) nul_seen = 1'b1;
          else if (!is_text(b)) text_bad = 1'b1;
        end
      end
      if (!l) begin
        if (pos != POS_MAX) pos = pos + 3'd1;
        return;
      end
      if (op_bad) why = REASON_BAD_OPCODE;
      else if (pos < LAST_POS_MIN) why = REASON_TOO_SHORT;
      else if (op == OP_AVAIL && pos < LAST_POS_MIN_AVAIL) why = REASON_TOO_SHORT;
      else if (op == OP_HEARTBEAT && pos < TAIL_START) why = REASON_OK;
      else if (op == OP_HEARTBEAT || op == OP_AVAIL) begin
        if (text_bad) why = REASON_BAD_CHAR;
        else if (!nul_seen) why = REASON_NO_NUL;
        else why = REASON_OK;
      end else why = REASON_OK;
      v.accept = (why == REASON_OK);
      v.reason = why;
      pending_verdicts.push_back(v);
      clear();
    endfunction

    function void check_verdict(logic [7:0] td);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected verdict, expected none, got tdata 0x%02h", $time, td);
        errors++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (td[0] !== v.accept) begin
        $display("%0t: accept mismatch, expected %0b, got %0b", $time, v.accept, td[0]);
        errors++;
      end
      if (td[3:1] !== v.reason) begin
        $display("%0t: reason mismatch, expected %0d, got %0d", $time, v.reason, td[3:1]);
        errors++;
      end
      if (td[7:4] !== 4'h0) begin
        $display("%0t: tdata pad mismatch, expected 0, got 0x%01h", $time, td[7:4]);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  packet_verdict_board board = new();
  bit quiet = 1'b0;
  int bytes_sent = 0;

  query_report_packet_validator dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // verdicts are checked before the request of the same edge is noted
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) board.check_verdict(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) board.note_request(s_axis_tdata, s_axis_tlast);
    end
  end

  // master side stalls in bursts
  initial begin
    repeat (12) @(posedge clk);
    m_axis_tready <= 1'b1;
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic l);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tlast <= l;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] pkt[$]);
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  // tail byte: 0 well formed, 1 broken, 2 noise
  function automatic logic [7:0] tail_byte(int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 2) return 8'($urandom);
    if (mode == 1 && r < 12) begin
      case ($urandom_range(0, 2))
        0: return 8'($urandom_range(8'h01, 8'h08));
        1: return 8'($urandom_range(8'h0E, 8'h1F));
        default: return 8'($urandom_range(8'h7F, 8'hFF));
      endcase
    end
    if (r < 30) return 8'h00;
    if (r < 40) return 8'($urandom_range(8'h09, 8'h0D));
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  task automatic random_packet();
    logic [7:0] pkt[$];
    int r;
    int len;
    int mode;
    r = $urandom_range(0, 99);
    if (r < 35) pkt.push_back({4'h0, OP_HEARTBEAT});
    else if (r < 70) pkt.push_back({4'h0, OP_AVAIL});
    else if (r < 88) pkt.push_back(8'($urandom_range(0, 9)));
    else pkt.push_back(8'($urandom_range(10, 255)));
    len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 24);
    r = $urandom_range(0, 99);
    mode = (r < 65) ? 0 : (r < 88) ? 1 : 2;
    for (int i = 1; i < len; i++) begin
      if (i < TAIL_START) pkt.push_back(8'($urandom));
      else pkt.push_back(tail_byte(mode));
    end
    send_packet(pkt);
  endtask

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // opcode boundary, short packets and each verdict of the text checks
    send_packet('{8'hFF});
    send_packet('{8'h0A, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46});
    send_packet('{8'h00, 8'hFF, 8'h80, 8'h7F});
    send_packet('{8'h05, 8'h00, 8'h00, 8'h00, 8'h00});
    send_packet('{8'h09, 8'h20, 8'h20, 8'h20, 8'h20});
    send_packet('{8'h03, 8'h01, 8'h02, 8'h03, 8'h04});
    // long heartbeat past the saturated position, nul at the end
    send_packet('{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h7E, 8'h09, 8'h0D,
                  8'h20, 8'h00});
    send_packet('{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h42});
    send_packet('{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h00});
    send_packet('{8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1F});
    // opcode 9 ignores what follows its first nul
    send_packet('{8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h01});
    send_packet('{8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h08, 8'h00});
    send_packet('{8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'h41, 8'h42});

    while (bytes_sent < 1950) begin
      if (bytes_sent > 1650) quiet = 1'b1;
      random_packet();
    end
    s_axis_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
design/qrpv_pkg.sv
design/qrpv_check.sv
design/query_report_packet_validator.sv
dv/query_report_packet_validator_tb.sv
